### src/dcm_pkg.sv
// shared types, constants and des permutation functions for the cbc-mac engine
`timescale 1ns / 1ps
package dcm_pkg;

	localparam logic [63:0] NIBBLE_FLIP = 64'hF0F0_F0F0_F0F0_F0F0;
	localparam logic [7:0]  PAD_MARKER  = 8'h80;

	localparam logic [2:0] XF_NONE   = 3'd1;
	localparam logic [2:0] XF_INVKEY = 3'd2;
	localparam logic [2:0] XF_RETAIL = 3'd3;
	localparam logic [2:0] XF_ALG4   = 3'd4;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [2:0] REG_KEY_MAIN   = 3'd0;
	localparam logic [2:0] REG_KEY_SECOND = 3'd1;
	localparam logic [2:0] REG_IV         = 3'd2;
	localparam logic [2:0] REG_USE_IV     = 3'd3;
	localparam logic [2:0] REG_PAD_MARK   = 3'd4;
	localparam logic [2:0] REG_LEN_PREFIX = 3'd5;
	localparam logic [2:0] REG_FINAL_XF   = 3'd6;
	localparam logic [2:0] REG_SKIP_XF    = 3'd7;

	typedef struct packed {
		logic        start;
		logic        decrypt;
		logic [63:0] key;
		logic [63:0] block;
	} des_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} des_rsp_t;

	typedef struct packed {
		logic [63:0] key_main;
		logic [63:0] key_second;
		logic [63:0] init_vector;
		logic        use_custom_iv;
		logic        pad_with_marker;
		logic        length_prefix_block;
		logic [2:0]  final_transform;
		logic        skip_output_transform;
	} cfg_t;

	typedef logic [7:0] tab64_t [64];
	typedef logic [7:0] tab56_t [56];
	typedef logic [7:0] tab48_t [48];
	typedef logic [7:0] tab32_t [32];
	typedef logic [3:0] sbox_t [8][64];

	localparam tab64_t T_IP = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
		64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam tab64_t T_FP = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
		37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam tab48_t T_EXP = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	localparam tab32_t T_P = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam tab56_t T_PC1 = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
		29,21,13,5,28,20,12,4};
	localparam tab48_t T_PC2 = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	localparam sbox_t T_SBOX = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic logic [63:0] des_ip(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(T_IP[i])];
		return r;
	endfunction

	function automatic logic [63:0] des_fp(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(T_FP[i])];
		return r;
	endfunction

	function automatic logic [55:0] des_pc1(input logic [63:0] x);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(T_PC1[i])];
		return r;
	endfunction

	function automatic logic [47:0] des_pc2(input logic [55:0] x);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(T_PC2[i])];
		return r;
	endfunction

	function automatic logic [31:0] des_feistel(input logic [31:0] h, input logic [47:0] sub);
		logic [47:0] e;
		logic [31:0] acc;
		logic [31:0] r;
		logic [5:0]  six;
		for (int i = 0; i < 48; i++) e[47-i] = h[32-int'(T_EXP[i])];
		e = e ^ sub;
		for (int s = 0; s < 8; s++) begin
			six = e[42-6*s +: 6];
			acc[28-4*s +: 4] = T_SBOX[s][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) r[31-i] = acc[32-int'(T_P[i])];
		return r;
	endfunction

endpackage

### src/dcm_des_core.sv
// iterative des unit, one round per cycle, key schedule rotated on the fly
`timescale 1ns / 1ps
module dcm_des_core import dcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  des_req_t req,
	output des_rsp_t rsp
);

	logic [3:0]  round_q;
	logic        busy_q;
	logic        done_q;
	logic        dec_q;
	logic [27:0] c_q, d_q;
	logic [31:0] l_q, r_q;
	logic [63:0] ip_blk;
	logic [55:0] cd0;
	logic [27:0] c_cur, d_cur;
	logic [1:0]  rot;
	logic [31:0] f_out;

	assign ip_blk = des_ip(req.block);
	assign cd0    = des_pc1(req.key);

	// shift for this round (1 on rounds 0, 1, 8, 15)
	always_comb begin
		rot = (round_q == 4'd0 || round_q == 4'd1 || round_q == 4'd8 || round_q == 4'd15)
			? 2'd1 : 2'd2;
	end

	// encrypt rotates left before use; decrypt uses the schedule backward:
	// first round uses the unrotated key, then rotates right
	always_comb begin
		if (!dec_q) begin
			c_cur = (rot == 2'd1) ? {c_q[26:0], c_q[27]} : {c_q[25:0], c_q[27:26]};
			d_cur = (rot == 2'd1) ? {d_q[26:0], d_q[27]} : {d_q[25:0], d_q[27:26]};
		end else begin
			c_cur = c_q;
			d_cur = d_q;
		end
	end

	assign f_out = des_feistel(r_q, des_pc2({c_cur, d_cur}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 4'd1;
				if (round_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dec_q <= req.decrypt;
			c_q   <= cd0[55:28];
			d_q   <= cd0[27:0];
			l_q   <= ip_blk[63:32];
			r_q   <= ip_blk[31:0];
		end else if (busy_q) begin
			l_q <= r_q;
			r_q <= l_q ^ f_out;
			if (!dec_q) begin
				c_q <= c_cur;
				d_q <= d_cur;
			end else begin
				// rotate right by the amount of the encrypt round 15-round_q
				if (round_q == 4'd0 || round_q == 4'd7 || round_q == 4'd14 ||
					round_q == 4'd15) begin
					c_q <= {c_q[0], c_q[27:1]};
					d_q <= {d_q[0], d_q[27:1]};
				end else begin
					c_q <= {c_q[1:0], c_q[27:2]};
					d_q <= {d_q[1:0], d_q[27:2]};
				end
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = des_fp({r_q, l_q});

endmodule

### src/dcm_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
module dcm_regs import dcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{default: '0, final_transform: XF_NONE};
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_KEY_MAIN:   cfg_q.key_main <= pwdata;
				REG_KEY_SECOND: cfg_q.key_second <= pwdata;
				REG_IV:         cfg_q.init_vector <= pwdata;
				REG_USE_IV:     cfg_q.use_custom_iv <= pwdata[0];
				REG_PAD_MARK:   cfg_q.pad_with_marker <= pwdata[0];
				REG_LEN_PREFIX: cfg_q.length_prefix_block <= pwdata[0];
				REG_FINAL_XF:   cfg_q.final_transform <= pwdata[2:0];
				REG_SKIP_XF:    cfg_q.skip_output_transform <= pwdata[0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY_MAIN:   prdata = cfg_q.key_main;
			REG_KEY_SECOND: prdata = cfg_q.key_second;
			REG_IV:         prdata = cfg_q.init_vector;
			REG_USE_IV:     prdata = {63'd0, cfg_q.use_custom_iv};
			REG_PAD_MARK:   prdata = {63'd0, cfg_q.pad_with_marker};
			REG_LEN_PREFIX: prdata = {63'd0, cfg_q.length_prefix_block};
			REG_FINAL_XF:   prdata = {61'd0, cfg_q.final_transform};
			REG_SKIP_XF:    prdata = {63'd0, cfg_q.skip_output_transform};
			default:        prdata = '0;
		endcase
	end

endmodule

### src/dcm_seq.sv
// message sequencer: chaining, padding and the output transform steps
`timescale 1ns / 1ps
module dcm_seq import dcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_op,
	input  logic [15:0] in_len,
	input  logic [63:0] in_blk,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_mac,
	output des_req_t    req,
	input  des_rsp_t    rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_RUN, S_LAUNCH, S_OUT
	} state_t;

	// steps of the des chain for one item
	typedef enum logic [2:0] {
		P_MAIN, P_INV, P_DEC2, P_ENC2, P_MAIN_AGAIN
	} step_t;

	state_t      state_q;
	step_t       step_q;
	logic [63:0] chain_q;
	logic [15:0] left_q;
	logic        first_q;
	logic        final_q;
	logic [63:0] mac_q;
	logic        fin_start;
	logic [63:0] padded;
	logic [63:0] mark;
	logic [2:0]  rem;
	logic        is_alg4;

	assign is_alg4 = cfg.final_transform == XF_ALG4;
	assign rem     = left_q[2:0];
	assign mark    = {56'd0, PAD_MARKER} << {3'd7 - rem, 3'b000};

	always_comb begin
		padded = in_blk;
		if (left_q < 16'd8) begin
			padded = (in_blk & ~(~64'd0 >> {rem, 3'b000}));
			if (cfg.pad_with_marker) padded = padded | mark;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_mac   = mac_q;
	assign fin_start = state_q == S_LAUNCH;

	always_comb begin
		req.start   = fin_start;
		req.decrypt = step_q == P_DEC2;
		req.block   = chain_q;
		unique case (step_q)
			P_INV:   req.key = cfg.key_second ^ NIBBLE_FLIP;
			P_DEC2:  req.key = cfg.key_second;
			P_ENC2:  req.key = cfg.key_second;
			default: req.key = cfg.key_main;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= P_MAIN;
			chain_q <= '0;
			left_q  <= '0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			mac_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q <= P_MAIN;
						if (in_op == OP_START) begin
							left_q  <= (in_len == 16'd0) ? 16'd8 : in_len;
							first_q <= 1'b1;
							final_q <= 1'b0;
							if (cfg.length_prefix_block) begin
								chain_q <= (cfg.use_custom_iv ? cfg.init_vector : 64'd0)
									^ {45'd0, in_len, 3'b000};
								state_q <= S_LAUNCH;
							end else begin
								chain_q <= cfg.use_custom_iv ? cfg.init_vector : 64'd0;
							end
						end else if (left_q != 16'd0) begin
							if (left_q > 16'd8) begin
								chain_q <= chain_q ^ in_blk;
								final_q <= 1'b0;
								left_q  <= left_q - 16'd8;
								state_q <= S_LAUNCH;
							end else begin
								chain_q <= chain_q ^ padded;
								final_q <= 1'b1;
								left_q  <= '0;
								if (cfg.skip_output_transform) begin
									mac_q   <= chain_q ^ padded;
									state_q <= S_OUT;
								end else begin
									state_q <= S_LAUNCH;
								end
							end
						end
					end
				end
				S_LAUNCH: state_q <= S_RUN;
				S_RUN: begin
					if (rsp.done) begin
						chain_q <= rsp.result;
						state_q <= S_IDLE;
						if (!final_q) begin
							// first encryption of a message under algorithm 4 adds the inverted-key pass
							if (step_q == P_MAIN && is_alg4 && first_q) begin
								step_q  <= P_INV;
								state_q <= S_LAUNCH;
							end else begin
								step_q <= P_MAIN;
							end
							first_q <= 1'b0;
						end else begin
							priority if (step_q == P_MAIN &&
								cfg.final_transform == XF_INVKEY) begin
								step_q <= P_INV; state_q <= S_LAUNCH;
							end else if (step_q == P_MAIN &&
								cfg.final_transform == XF_RETAIL) begin
								step_q <= P_DEC2; state_q <= S_LAUNCH;
							end else if (step_q == P_DEC2) begin
								step_q <= P_MAIN_AGAIN; state_q <= S_LAUNCH;
							end else if (step_q == P_MAIN && is_alg4) begin
								step_q <= P_ENC2; state_q <= S_LAUNCH;
							end else begin
								mac_q   <= rsp.result;
								state_q <= S_OUT;
							end
						end
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/des_cbc_mac_engine.sv
// Single-DES CBC-MAC engine (ISO 9797-1). DES passes run through one iterative
// DES unit doing one round per clock: a data block is accepted, launched, runs its
// 16 rounds and has its result captured. The block that ends a message runs up to
// two more passes for the output transform before its MAC is offered, or runs no
// DES pass at all when the output transform is skipped. A start item with the
// length prefix costs one or two DES passes; without it a start item only loads
// the chain value. One item is in work at a time; s_tready is low until its passes
// finish and, for the block that ends a message, until the MAC is taken.
`timescale 1ns / 1ps
module des_cbc_mac_engine import dcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // message_length[15:0], data_block[79:16], zeros
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // mac_value
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	cfg_t     cfg;
	des_req_t req;
	des_rsp_t rsp;
	logic     unused_pad;

	assign unused_pad = ^s_tdata[87:80];

	dcm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	dcm_seq u_seq (
		.clk, .arst_n, .cfg,
		.in_valid (s_tvalid & ~unused_pad | s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_len   (s_tdata[15:0]),
		.in_blk   (s_tdata[79:16]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_mac  (m_tdata),
		.req, .rsp
	);

	dcm_des_core u_des (.clk, .arst_n, .req, .rsp);

endmodule

### src/dcm_checker.sv
// port-level checks for the cbc-mac engine
`timescale 1ns / 1ps
module dcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("mac word dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready)) else $error("input taken while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid) else $error("mac word repeated");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind des_cbc_mac_engine dcm_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .pready
);
